// ===== rtl/sle_pkg.sv =====
// Shared constants for the serial line editor.
// No dependencies; compiled first.
package sle_pkg;

    // Result field widths
    localparam int KIND_W  = 2;
    localparam int BYTE_W  = 8;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 6;
    localparam int LIMIT_W    = 6;
    localparam int MODE_W     = 2;

    localparam logic [CFG_IDX_W-1:0] REG_LINE_LIMIT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CASE_MODE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ECHO_ENABLE = 2'd2;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 6'd32;

    // Case folding modes; any other code keeps the case
    localparam logic [MODE_W-1:0] CASE_KEEP  = 2'd0;
    localparam logic [MODE_W-1:0] CASE_UPPER = 2'd1;
    localparam logic [MODE_W-1:0] CASE_LOWER = 2'd2;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_ECHO = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CHAR = 2'd1;
    localparam logic [KIND_W-1:0] KIND_END  = 2'd2;

    // Character codes
    localparam logic [BYTE_W-1:0] CH_BS    = 8'h08;
    localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CH_DEL   = 8'h7F;
    localparam logic [BYTE_W-1:0] CH_UC_A  = 8'h41;
    localparam logic [BYTE_W-1:0] CH_UC_Z  = 8'h5A;
    localparam logic [BYTE_W-1:0] CH_LC_A  = 8'h61;
    localparam logic [BYTE_W-1:0] CH_LC_Z  = 8'h7A;
    localparam logic [BYTE_W-1:0] CASE_OFS = 8'h20;

endpackage

// ===== rtl/sle_rx_if.sv =====
// Receive channel: one byte per request, valid/ready handshake.
// Depends on sle_pkg.
interface sle_rx_if;
    logic                       valid;
    logic                       ready;
    logic [sle_pkg::BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

// ===== rtl/sle_res_if.sv =====
// Result channel: echo bytes, line characters and end markers.
// Depends on sle_pkg.
interface sle_res_if;
    logic                       valid;
    logic                       ready;
    logic [sle_pkg::KIND_W-1:0] kind;
    logic [sle_pkg::BYTE_W-1:0] value;
    logic                       last;

    modport source (output valid, output kind, output value, output last, input ready);
    modport sink   (input valid, input kind, input value, input last, output ready);
endinterface

// ===== rtl/sle_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/serial_line_editor.sv =====
// Serial line editor top level: case folding, line store editing, echo and
// line flush under one small sequencer.
// Depends on sle_pkg, sle_rx_if, sle_res_if and sle_ram.

// The block takes one received byte per request and answers with zero or
// more results on the result channel; the final result of a request carries
// last. Printable bytes are stored while the line has room and then echoed,
// backspace/DEL erase one character if the line is not empty (echo: byte,
// space, byte), carriage return echoes CR LF and then streams the stored
// line followed by an end marker holding the length; each echo happens only
// with echo enabled. Configuration writes are taken at any time but must only
// be issued while no request is in progress. A new byte is accepted only once
// the request before it is done; a stall on the result side holds the block.
// The flush is paced by the single read port of the line store, which
// streams one character per cycle while the result side accepts. A finished
// result waits in the output register while the next byte is accepted.
module serial_line_editor #(
    parameter int LINE_MAX = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    sle_rx_if.sink                            rx,
    sle_res_if.source                         res,
    input  logic                              cfg_we,
    input  logic [sle_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [sle_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int CW = $clog2(LINE_MAX);
    localparam logic [sle_pkg::LIMIT_W-1:0] LIMIT_CAP = sle_pkg::LIMIT_W'(LINE_MAX);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DECODE,
        ST_ECHO,
        ST_FLUSH
    } state_t;

    // Echo sequence selected by the decoder
    typedef enum logic [1:0] {
        OP_CR,
        OP_DEL,
        OP_CHAR
    } echo_op_t;

    state_t                         state_reg, state_next;
    echo_op_t                       op_reg, op_next;
    logic [1:0]                     step_reg, step_next;
    logic [sle_pkg::BYTE_W-1:0]     byte_reg, byte_next;
    logic [CW-1:0]                  count_reg, count_next;
    logic [CW-1:0]                  flush_idx_reg, flush_idx_next;

    logic [sle_pkg::LIMIT_W-1:0]    line_limit_reg, line_limit_next;
    logic [sle_pkg::MODE_W-1:0]     case_mode_reg, case_mode_next;
    logic                           echo_enable_reg, echo_enable_next;

    logic                           res_valid_reg, res_valid_next;
    logic [sle_pkg::KIND_W-1:0]     res_kind_reg, res_kind_next;
    logic [sle_pkg::BYTE_W-1:0]     res_value_reg, res_value_next;
    logic                           res_last_reg, res_last_next;

    logic [sle_pkg::BYTE_W-1:0]     folded;
    logic [sle_pkg::LIMIT_W-1:0]    lim;
    logic [sle_pkg::LIMIT_W-1:0]    keep;
    logic                           can_emit;
    logic                           ram_we;
    logic [sle_pkg::BYTE_W-1:0]     ram_rdata;

    // Line store. The read address follows the next flush index so that the
    // registered read data always matches flush_idx_reg during the flush.
    sle_ram #(
        .WIDTH (sle_pkg::BYTE_W),
        .DEPTH (LINE_MAX)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg),
        .wdata (byte_reg),
        .raddr (flush_idx_next),
        .rdata (ram_rdata)
    );

    // Case folding of the incoming byte, letters only
    always_comb
    begin
        folded = rx.rx_byte;
        if (case_mode_reg == sle_pkg::CASE_UPPER &&
            rx.rx_byte >= sle_pkg::CH_LC_A && rx.rx_byte <= sle_pkg::CH_LC_Z)
        begin
            folded = rx.rx_byte - sle_pkg::CASE_OFS;
        end
        else if (case_mode_reg == sle_pkg::CASE_LOWER &&
                 rx.rx_byte >= sle_pkg::CH_UC_A && rx.rx_byte <= sle_pkg::CH_UC_Z)
        begin
            folded = rx.rx_byte + sle_pkg::CASE_OFS;
        end
    end

    // Usable length: limit saturated to the store size, one slot reserved
    assign lim  = (line_limit_reg > LIMIT_CAP) ? LIMIT_CAP : line_limit_reg;
    assign keep = (lim == '0) ? '0 : lim - 1'b1;

    assign can_emit  = !res_valid_reg || res.ready;
    assign rx.ready  = (state_reg == ST_IDLE);
    assign res.valid = res_valid_reg;
    assign res.kind  = res_kind_reg;
    assign res.value = res_value_reg;
    assign res.last  = res_last_reg;

    // Configuration writes; unknown indexes are ignored
    always_comb
    begin
        line_limit_next  = line_limit_reg;
        case_mode_next   = case_mode_reg;
        echo_enable_next = echo_enable_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                sle_pkg::REG_LINE_LIMIT:  line_limit_next  = cfg_data;
                sle_pkg::REG_CASE_MODE:   case_mode_next   = cfg_data[sle_pkg::MODE_W-1:0];
                sle_pkg::REG_ECHO_ENABLE: echo_enable_next = cfg_data[0];
                default: ;
            endcase
        end
    end

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        step_next      = step_reg;
        byte_next      = byte_reg;
        count_next     = count_reg;
        flush_idx_next = '0;
        ram_we         = 1'b0;
        res_valid_next = res_valid_reg && !res.ready;
        res_kind_next  = res_kind_reg;
        res_value_next = res_value_reg;
        res_last_next  = res_last_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (rx.valid)
                begin
                    byte_next  = folded;
                    state_next = ST_DECODE;
                end
            end

            ST_DECODE:
            begin
                step_next  = 2'd0;
                state_next = ST_IDLE;
                if (byte_reg == sle_pkg::CH_CR)
                begin
                    op_next    = OP_CR;
                    state_next = echo_enable_reg ? ST_ECHO : ST_FLUSH;
                end
                else if (byte_reg == sle_pkg::CH_BS || byte_reg == sle_pkg::CH_DEL)
                begin
                    if (count_reg != '0)
                    begin
                        count_next = count_reg - 1'b1;
                        op_next    = OP_DEL;
                        if (echo_enable_reg)
                        begin
                            state_next = ST_ECHO;
                        end
                    end
                end
                else if (byte_reg >= sle_pkg::CH_SPACE && byte_reg < sle_pkg::CH_DEL)
                begin
                    // keep never exceeds LINE_MAX-1, so the store bound follows
                    if (sle_pkg::LIMIT_W'(count_reg) < keep)
                    begin
                        ram_we     = 1'b1;
                        count_next = count_reg + 1'b1;
                        op_next    = OP_CHAR;
                        if (echo_enable_reg)
                        begin
                            state_next = ST_ECHO;
                        end
                    end
                end
            end

            ST_ECHO:
            begin
                if (can_emit)
                begin
                    res_valid_next = 1'b1;
                    res_kind_next  = sle_pkg::KIND_ECHO;
                    res_last_next  = 1'b0;
                    step_next      = step_reg + 1'b1;
                    case (op_reg)
                        OP_CR:
                        begin
                            res_value_next = (step_reg == 2'd0) ? sle_pkg::CH_CR
                                                                : sle_pkg::CH_LF;
                            if (step_reg != 2'd0)
                            begin
                                state_next = ST_FLUSH;
                            end
                        end
                        OP_DEL:
                        begin
                            res_value_next = (step_reg == 2'd1) ? sle_pkg::CH_SPACE
                                                                : byte_reg;
                            if (step_reg == 2'd2)
                            begin
                                res_last_next = 1'b1;
                                state_next    = ST_IDLE;
                            end
                        end
                        default:
                        begin
                            res_value_next = byte_reg;
                            res_last_next  = 1'b1;
                            state_next     = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_FLUSH:
            begin
                flush_idx_next = flush_idx_reg;
                if (can_emit)
                begin
                    res_valid_next = 1'b1;
                    if (flush_idx_reg == count_reg)
                    begin
                        res_kind_next  = sle_pkg::KIND_END;
                        res_value_next = sle_pkg::BYTE_W'(count_reg);
                        res_last_next  = 1'b1;
                        count_next     = '0;
                        flush_idx_next = '0;
                        state_next     = ST_IDLE;
                    end
                    else
                    begin
                        res_kind_next  = sle_pkg::KIND_CHAR;
                        res_value_next = ram_rdata;
                        res_last_next  = 1'b0;
                        flush_idx_next = flush_idx_reg + 1'b1;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State, configuration and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            op_reg          <= OP_CHAR;
            step_reg        <= 2'd0;
            count_reg       <= '0;
            flush_idx_reg   <= '0;
            line_limit_reg  <= sle_pkg::LIMIT_RESET;
            case_mode_reg   <= sle_pkg::CASE_KEEP;
            echo_enable_reg <= 1'b1;
            res_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            op_reg          <= op_next;
            step_reg        <= step_next;
            count_reg       <= count_next;
            flush_idx_reg   <= flush_idx_next;
            line_limit_reg  <= line_limit_next;
            case_mode_reg   <= case_mode_next;
            echo_enable_reg <= echo_enable_next;
            res_valid_reg   <= res_valid_next;
        end
    end

    // Payload registers, no reset
    always_ff @(posedge clk)
    begin
        byte_reg      <= byte_next;
        res_kind_reg  <= res_kind_next;
        res_value_reg <= res_value_next;
        res_last_reg  <= res_last_next;
    end

    // Line never grows past the store
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        sle_pkg::LIMIT_W'(count_reg) <= LIMIT_CAP - 6'd1)
        else $error("char count beyond store size");

    // An end marker leaves an empty line behind
    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FLUSH && can_emit && flush_idx_reg == count_reg)
        |=> (count_reg == '0))
        else $error("line not cleared after end marker");

    // The final result of a request returns the sequencer to idle
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_next && res_last_next && can_emit && state_reg != ST_IDLE)
        |=> (state_reg == ST_IDLE))
        else $error("sequencer busy after final result");

    // The count only moves while decoding or finishing a flush
    a_count_moves: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(count_reg) |-> ($past(state_reg) == ST_DECODE ||
                                 $past(state_reg) == ST_FLUSH))
        else $error("char count changed outside decode or flush");

endmodule
